// ===== rtl/core/ahdh_pkg.sv =====
`timescale 1ns / 1ps

package ahdh_pkg;

  localparam int unsigned LevelW  = 12;
  localparam int unsigned DistW   = 24;
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned TickW   = 10;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 4;

  // speed * tick, and the steps of the divide by 360 (shift by 3, then a
  // reciprocal multiply for the remaining factor of 45).
  localparam int unsigned ProdW      = SpeedW + TickW;
  localparam int unsigned DivPreSh   = 3;
  localparam int unsigned QuotInW    = ProdW - DivPreSh;
  localparam int unsigned RecipW     = 23;
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipFullW = QuotInW + RecipW;
  localparam int unsigned MoveW      = 17;

  localparam logic [RecipW-1:0] RecipMul = 23'd5965233;

  localparam logic [DistW-1:0] AccMax          = {DistW{1'b1}};
  localparam logic [DistW-1:0] OffTunnelDistMm = 24'd20000;
  localparam logic [TimeW-1:0] StartupWindowMs = 32'd5000;
  localparam logic [TimeW-1:0] MinOnMs         = 32'd10000;
  localparam logic [TimeW-1:0] LowSpeedHoldMs  = 32'd3000;
  localparam logic [SpeedW-1:0] LowSpeedCentiKmh = 15'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartupDarkLevel = 4'd0,
    CfgDuskLevel        = 4'd1,
    CfgTunnelLevel      = 4'd2,
    CfgOffLevel         = 4'd3,
    CfgOffTunnelLevel   = 4'd4,
    CfgDuskDistanceMm   = 4'd5,
    CfgTunnelDistanceMm = 4'd6,
    CfgOffDistanceMm    = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] startup_dark_level;
    logic [LevelW-1:0] dusk_level;
    logic [LevelW-1:0] tunnel_level;
    logic [LevelW-1:0] off_level;
    logic [LevelW-1:0] off_tunnel_level;
    logic [DistW-1:0]  dusk_distance_mm;
    logic [DistW-1:0]  tunnel_distance_mm;
    logic [DistW-1:0]  off_distance_mm;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic [TimeW-1:0]  time_ms;
    logic              link_active;
    logic              low_speed;
  } tick_info_t;

  typedef struct packed {
    tick_info_t       info;
    logic [MoveW-1:0] move_mm;
  } move_word_t;

endpackage

// ===== rtl/core/ahdh_cfg.sv =====
`timescale 1ns / 1ps

module ahdh_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ahdh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ahdh_pkg::DistW-1:0]    cfg_data_i,
  output ahdh_pkg::cfg_t                cfg_o
);
  import ahdh_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStartupDarkLevel: cfg_d.startup_dark_level = cfg_data_i[LevelW-1:0];
        CfgDuskLevel:        cfg_d.dusk_level         = cfg_data_i[LevelW-1:0];
        CfgTunnelLevel:      cfg_d.tunnel_level       = cfg_data_i[LevelW-1:0];
        CfgOffLevel:         cfg_d.off_level          = cfg_data_i[LevelW-1:0];
        CfgOffTunnelLevel:   cfg_d.off_tunnel_level   = cfg_data_i[LevelW-1:0];
        CfgDuskDistanceMm:   cfg_d.dusk_distance_mm   = cfg_data_i;
        CfgTunnelDistanceMm: cfg_d.tunnel_distance_mm = cfg_data_i;
        CfgOffDistanceMm:    cfg_d.off_distance_mm    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_dark_level <= 12'd1228;
      cfg_q.dusk_level         <= 12'd1228;
      cfg_q.tunnel_level       <= 12'd409;
      cfg_q.off_level          <= 12'd2048;
      cfg_q.off_tunnel_level   <= 12'd1638;
      cfg_q.dusk_distance_mm   <= 24'd100000;
      cfg_q.tunnel_distance_mm <= 24'd30000;
      cfg_q.off_distance_mm    <= 24'd200000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ahdh_move.sv =====
`timescale 1ns / 1ps

module ahdh_move (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ahdh_pkg::LevelW-1:0]  brightness_i,
  input  logic [ahdh_pkg::SpeedW-1:0]  speed_centi_kmh_i,
  input  logic [ahdh_pkg::TickW-1:0]   tick_ms_i,
  input  logic [ahdh_pkg::TimeW-1:0]   time_ms_i,
  input  logic                         link_active_i,
  output logic                         move_valid_o,
  input  logic                         move_ready_i,
  output ahdh_pkg::move_word_t         move_o
);
  import ahdh_pkg::*;

  // Three stages: captured word, speed times tick, distance in millimetres.
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  tick_info_t        a_info_q, b_info_q, c_info_q;
  logic [SpeedW-1:0] a_speed_q;
  logic [TickW-1:0]  a_tick_q;
  logic [ProdW-1:0]  b_prod_q, b_prod_d;
  logic [MoveW-1:0]  c_move_q, c_move_d;
  logic [QuotInW-1:0]    quot_in;
  logic [RecipFullW-1:0] recip_full;

  assign c_ready    = !c_valid_q || move_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign b_prod_d   = ProdW'(a_speed_q) * ProdW'(a_tick_q);
  assign quot_in    = b_prod_q[ProdW-1:DivPreSh];
  assign recip_full = RecipFullW'(quot_in) * RecipFullW'(RecipMul);
  assign c_move_d   = recip_full[RecipShift+MoveW-1:RecipShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_info_q.brightness  <= brightness_i;
      a_info_q.time_ms     <= time_ms_i;
      a_info_q.link_active <= link_active_i;
      a_info_q.low_speed   <= (speed_centi_kmh_i <= LowSpeedCentiKmh);
      a_speed_q            <= speed_centi_kmh_i;
      a_tick_q             <= tick_ms_i;
    end
    if (b_ready && a_valid_q) begin
      b_info_q <= a_info_q;
      b_prod_q <= b_prod_d;
    end
    if (c_ready && b_valid_q) begin
      c_info_q <= b_info_q;
      c_move_q <= c_move_d;
    end
  end

  assign move_valid_o    = c_valid_q;
  assign move_o.info     = c_info_q;
  assign move_o.move_mm  = c_move_q;

endmodule

// ===== rtl/core/ahdh_ctrl.sv =====
`timescale 1ns / 1ps

module ahdh_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ahdh_pkg::cfg_t              cfg_i,
  input  logic                        move_valid_i,
  output logic                        move_ready_o,
  input  ahdh_pkg::move_word_t        move_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        light_on_o,
  output logic                        in_startup_o,
  output logic [ahdh_pkg::DistW-1:0]  dusk_accum_mm_o,
  output logic [ahdh_pkg::DistW-1:0]  off_accum_mm_o
);
  import ahdh_pkg::*;

  function automatic logic [DistW-1:0] sat_add(logic [DistW-1:0] acc, logic [MoveW-1:0] add);
    logic [DistW:0] s;
    s = {1'b0, acc} + (DistW+1)'(add);
    return s[DistW] ? AccMax : s[DistW-1:0];
  endfunction

  logic startup_done_q, startup_done_d;
  logic link_seen_q, link_seen_d;
  logic lamp_q, lamp_d;
  logic [TimeW-1:0] on_since_q, on_since_d;
  logic [TimeW-1:0] link_since_q, link_since_d;
  logic [TimeW-1:0] dark_since_q, dark_since_d;
  logic [DistW-1:0] tunnel_acc_q, tunnel_acc_d;
  logic [DistW-1:0] dusk_acc_q, dusk_acc_d;
  logic [DistW-1:0] off_acc_q, off_acc_d;
  logic [DistW-1:0] off_tun_acc_q, off_tun_acc_d;
  logic out_valid_q;
  logic advance;

  logic [LevelW-1:0] bright;
  logic [TimeW-1:0]  now;
  logic [MoveW-1:0]  move;

  assign bright       = move_i.info.brightness;
  assign now          = move_i.info.time_ms;
  assign move         = move_i.move_mm;
  assign move_ready_o = !out_valid_q || out_ready_i;
  assign advance      = move_valid_i && move_ready_o;

  always_comb begin
    logic run;
    logic lamp_cur;
    logic can_off;
    run            = 1'b1;
    lamp_cur       = 1'b0;
    can_off        = 1'b0;
    startup_done_d = startup_done_q;
    link_seen_d    = link_seen_q;
    lamp_d         = lamp_q;
    on_since_d     = on_since_q;
    link_since_d   = link_since_q;
    dark_since_d   = dark_since_q;
    tunnel_acc_d   = tunnel_acc_q;
    dusk_acc_d     = dusk_acc_q;
    off_acc_d      = off_acc_q;
    off_tun_acc_d  = off_tun_acc_q;

    if (!startup_done_q) begin
      if (move_i.info.link_active && !link_seen_q) begin
        link_seen_d  = 1'b1;
        link_since_d = now;
      end
      if (link_seen_d) begin
        if (bright <= cfg_i.startup_dark_level) begin
          lamp_d         = 1'b1;
          on_since_d     = now;
          startup_done_d = 1'b1;
        end else if ((now - link_since_d) >= StartupWindowMs) begin
          startup_done_d = 1'b1;
        end
      end
      if (!startup_done_d) begin
        run = 1'b0;
      end
    end

    if (run && !move_i.info.link_active) begin
      lamp_d        = 1'b0;
      tunnel_acc_d  = '0;
      dusk_acc_d    = '0;
      off_acc_d     = '0;
      off_tun_acc_d = '0;
      dark_since_d  = '0;
      run           = 1'b0;
    end

    lamp_cur = lamp_d;
    if (run) begin
      if (!lamp_cur) begin
        if (bright <= cfg_i.tunnel_level) begin
          tunnel_acc_d = sat_add(tunnel_acc_q, move);
          if (dark_since_q == '0) begin
            dark_since_d = now;
          end
          if ((tunnel_acc_d >= cfg_i.tunnel_distance_mm) ||
              (move_i.info.low_speed && ((now - dark_since_d) >= LowSpeedHoldMs))) begin
            lamp_d     = 1'b1;
            on_since_d = now;
          end
        end else begin
          tunnel_acc_d = '0;
          dark_since_d = '0;
        end
        if (bright <= cfg_i.dusk_level) begin
          dusk_acc_d = sat_add(dusk_acc_q, move);
          if (dusk_acc_d >= cfg_i.dusk_distance_mm) begin
            lamp_d     = 1'b1;
            on_since_d = now;
          end
        end else begin
          dusk_acc_d = '0;
        end
        off_acc_d     = '0;
        off_tun_acc_d = '0;
      end else begin
        can_off       = (now - on_since_d) >= MinOnMs;
        off_acc_d     = (bright > cfg_i.off_level) ? sat_add(off_acc_q, move) : '0;
        off_tun_acc_d = (bright > cfg_i.off_tunnel_level) ?
                        sat_add(off_tun_acc_q, move) : '0;
        if (can_off && ((off_acc_d >= cfg_i.off_distance_mm) ||
                        (off_tun_acc_d >= OffTunnelDistMm))) begin
          lamp_d       = 1'b0;
          tunnel_acc_d = '0;
          dusk_acc_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_done_q <= 1'b0;
      link_seen_q    <= 1'b0;
      lamp_q         <= 1'b0;
      on_since_q     <= '0;
      link_since_q   <= '0;
      dark_since_q   <= '0;
      tunnel_acc_q   <= '0;
      dusk_acc_q     <= '0;
      off_acc_q      <= '0;
      off_tun_acc_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (advance) begin
        startup_done_q <= startup_done_d;
        link_seen_q    <= link_seen_d;
        lamp_q         <= lamp_d;
        on_since_q     <= on_since_d;
        link_since_q   <= link_since_d;
        dark_since_q   <= dark_since_d;
        tunnel_acc_q   <= tunnel_acc_d;
        dusk_acc_q     <= dusk_acc_d;
        off_acc_q      <= off_acc_d;
        off_tun_acc_q  <= off_tun_acc_d;
      end
      if (move_ready_o) begin
        out_valid_q <= move_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      light_on_o      <= lamp_d;
      in_startup_o    <= !startup_done_d;
      dusk_accum_mm_o <= dusk_acc_d;
      off_accum_mm_o  <= off_acc_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/auto_headlight_distance_hysteresis.sv =====
`timescale 1ns / 1ps

// Automatic headlight controller: one control tick word in, one result word out. A new word
// is taken in every clock cycle unless the result side stalls; each word passes
// through a capture register, a speed-times-tick multiply stage, a divide-by-360 stage and the
// result register. The lamp state update is combinational and is registered when a word is
// taken, so that each word sees the state left by the one before it. Configuration writes take
// effect on the following edge and are meant to be made while no word is in flight.
module auto_headlight_distance_hysteresis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ahdh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ahdh_pkg::DistW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ahdh_pkg::LevelW-1:0]   brightness_i,
  input  logic [ahdh_pkg::SpeedW-1:0]   speed_centi_kmh_i,
  input  logic [ahdh_pkg::TickW-1:0]    tick_ms_i,
  input  logic [ahdh_pkg::TimeW-1:0]    time_ms_i,
  input  logic                          link_active_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          light_on_o,
  output logic                          in_startup_o,
  output logic [ahdh_pkg::DistW-1:0]    dusk_accum_mm_o,
  output logic [ahdh_pkg::DistW-1:0]    off_accum_mm_o
);
  import ahdh_pkg::*;

  cfg_t       cfg;
  move_word_t move_word;
  logic       move_valid;
  logic       move_ready;

  ahdh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ahdh_move u_move (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .brightness_i      (brightness_i),
    .speed_centi_kmh_i (speed_centi_kmh_i),
    .tick_ms_i         (tick_ms_i),
    .time_ms_i         (time_ms_i),
    .link_active_i     (link_active_i),
    .move_valid_o      (move_valid),
    .move_ready_i      (move_ready),
    .move_o            (move_word)
  );

  ahdh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .move_valid_i    (move_valid),
    .move_ready_o    (move_ready),
    .move_i          (move_word),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .light_on_o      (light_on_o),
    .in_startup_o    (in_startup_o),
    .dusk_accum_mm_o (dusk_accum_mm_o),
    .off_accum_mm_o  (off_accum_mm_o)
  );

endmodule

// ===== tb/tb_auto_headlight_distance_hysteresis.sv =====
`timescale 1ns / 1ps

module tb_auto_headlight_distance_hysteresis;
  import ahdh_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumRegs       = 8;
  localparam int unsigned MmDivisor     = 360;
  localparam int unsigned PhaseItems    = 120;

  localparam logic [LevelW-1:0] LevelMax = '1;
  localparam logic [SpeedW-1:0] SpeedMax = '1;
  localparam logic [TickW-1:0]  TickMax  = '1;

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic [SpeedW-1:0] speed;
    logic [TickW-1:0]  tick_len;
    logic [TimeW-1:0]  stamp;
    logic              link;
  } tick_t;

  typedef struct packed {
    logic             light_on;
    logic             in_startup;
    logic [DistW-1:0] dusk_mm;
    logic [DistW-1:0] off_mm;
  } lamp_status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DistW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [LevelW-1:0]  brightness_i;
  logic [SpeedW-1:0]  speed_centi_kmh_i;
  logic [TickW-1:0]   tick_ms_i;
  logic [TimeW-1:0]   time_ms_i;
  logic               link_active_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               light_on_o;
  logic               in_startup_o;
  logic [DistW-1:0]   dusk_accum_mm_o;
  logic [DistW-1:0]   off_accum_mm_o;

  auto_headlight_distance_hysteresis i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .brightness_i      (brightness_i),
    .speed_centi_kmh_i (speed_centi_kmh_i),
    .tick_ms_i         (tick_ms_i),
    .time_ms_i         (time_ms_i),
    .link_active_i     (link_active_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .light_on_o        (light_on_o),
    .in_startup_o      (in_startup_o),
    .dusk_accum_mm_o   (dusk_accum_mm_o),
    .off_accum_mm_o    (off_accum_mm_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Lamp controller state as the predictor sees it.
  cfg_t             lamp_cfg;
  logic             started, link_seen, lamp_lit;
  logic [TimeW-1:0] lit_since, link_since, dark_since;
  logic [DistW-1:0] tunnel_acc, dusk_acc, off_acc, exit_acc;

  lamp_status_t     status_q[$];
  logic [TimeW-1:0] now_ms;
  int unsigned      mismatches = 0;
  int unsigned      words_sent = 0;
  int unsigned      words_checked = 0;
  int unsigned      switch_ons = 0;
  int unsigned      settings_applied = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      mood_left = 0;
  int unsigned      stall_left = 0;
  logic             calm_in = 1'b0;
  logic             calm_out = 1'b0;
  logic             last_light = 1'b0;

  function automatic cfg_t reset_settings();
    cfg_t c;
    c.startup_dark_level = 12'd1228;
    c.dusk_level         = 12'd1228;
    c.tunnel_level       = 12'd409;
    c.off_level          = 12'd2048;
    c.off_tunnel_level   = 12'd1638;
    c.dusk_distance_mm   = 24'd100000;
    c.tunnel_distance_mm = 24'd30000;
    c.off_distance_mm    = 24'd200000;
    return c;
  endfunction

  function automatic logic [DistW-1:0] sat_sum(input logic [DistW-1:0] acc,
                                               input logic [31:0] add);
    logic [32:0] s;
    s = 33'(acc) + 33'(add);
    return (s > 33'(AccMax)) ? AccMax : s[DistW-1:0];
  endfunction

  function automatic lamp_status_t lamp_step(input tick_t t);
    logic         active;
    logic         can_off;
    logic [31:0]  travel;
    lamp_status_t r;
    active = 1'b1;
    if (!started) begin
      if (t.link && !link_seen) begin
        link_seen  = 1'b1;
        link_since = t.stamp;
      end
      if (link_seen) begin
        if (t.brightness <= lamp_cfg.startup_dark_level) begin
          lamp_lit  = 1'b1;
          lit_since = t.stamp;
          started   = 1'b1;
        end else if (TimeW'(t.stamp - link_since) >= StartupWindowMs) begin
          started = 1'b1;
        end
      end
      if (!started) active = 1'b0;
    end
    if (active && !t.link) begin
      lamp_lit   = 1'b0;
      tunnel_acc = '0;
      dusk_acc   = '0;
      off_acc    = '0;
      exit_acc   = '0;
      dark_since = '0;
      active     = 1'b0;
    end
    if (active) begin
      travel = (32'(t.speed) * 32'(t.tick_len)) / MmDivisor;
      if (!lamp_lit) begin
        if (t.brightness <= lamp_cfg.tunnel_level) begin
          tunnel_acc = sat_sum(tunnel_acc, travel);
          if (dark_since == '0) dark_since = t.stamp;
          if (tunnel_acc >= lamp_cfg.tunnel_distance_mm ||
              (t.speed <= LowSpeedCentiKmh &&
               TimeW'(t.stamp - dark_since) >= LowSpeedHoldMs)) begin
            lamp_lit  = 1'b1;
            lit_since = t.stamp;
          end
        end else begin
          tunnel_acc = '0;
          dark_since = '0;
        end
        if (t.brightness <= lamp_cfg.dusk_level) begin
          dusk_acc = sat_sum(dusk_acc, travel);
          if (dusk_acc >= lamp_cfg.dusk_distance_mm) begin
            lamp_lit  = 1'b1;
            lit_since = t.stamp;
          end
        end else begin
          dusk_acc = '0;
        end
        off_acc  = '0;
        exit_acc = '0;
      end else begin
        can_off  = TimeW'(t.stamp - lit_since) >= MinOnMs;
        off_acc  = (t.brightness > lamp_cfg.off_level) ? sat_sum(off_acc, travel) : '0;
        exit_acc = (t.brightness > lamp_cfg.off_tunnel_level) ?
                   sat_sum(exit_acc, travel) : '0;
        if (can_off && (off_acc >= lamp_cfg.off_distance_mm ||
                        exit_acc >= OffTunnelDistMm)) begin
          lamp_lit   = 1'b0;
          tunnel_acc = '0;
          dusk_acc   = '0;
        end
      end
    end
    r.light_on   = lamp_lit;
    r.in_startup = !started;
    r.dusk_mm    = dusk_acc;
    r.off_mm     = off_acc;
    return r;
  endfunction

  function automatic tick_t tick_word(input logic [LevelW-1:0] b, input logic [SpeedW-1:0] s,
                                      input logic [TickW-1:0] d, input logic [TimeW-1:0] st,
                                      input logic l);
    tick_t t;
    t.brightness = b;
    t.speed      = s;
    t.tick_len   = d;
    t.stamp      = st;
    t.link       = l;
    return t;
  endfunction

  function automatic logic [LevelW-1:0] level_between(input logic [LevelW-1:0] a,
                                                      input logic [LevelW-1:0] b);
    if (a > b) return LevelW'($urandom_range(b, a));
    return LevelW'($urandom_range(a, b));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_in) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    brightness_i      <= t.brightness;
    speed_centi_kmh_i <= t.speed;
    tick_ms_i         <= t.tick_len;
    time_ms_i         <= t.stamp;
    link_active_i     <= t.link;
    do @(posedge clk_i); while (!in_ready_o);
    status_q.push_back(lamp_step(t));
    words_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c);
    cfg_idx_e         idx;
    logic [DistW-1:0] data;
    idx = idx.first();
    do begin
      data = DistW'($urandom);
      case (idx)
        CfgStartupDarkLevel: data[LevelW-1:0] = c.startup_dark_level;
        CfgDuskLevel:        data[LevelW-1:0] = c.dusk_level;
        CfgTunnelLevel:      data[LevelW-1:0] = c.tunnel_level;
        CfgOffLevel:         data[LevelW-1:0] = c.off_level;
        CfgOffTunnelLevel:   data[LevelW-1:0] = c.off_tunnel_level;
        CfgDuskDistanceMm:   data = c.dusk_distance_mm;
        CfgTunnelDistanceMm: data = c.tunnel_distance_mm;
        CfgOffDistanceMm:    data = c.off_distance_mm;
        default:             data = '0;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    // An unmapped index must leave every register alone.
    cfg_index_i <= CfgIdxW'(NumRegs + $urandom_range(0, 7));
    cfg_data_i  <= DistW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lamp_cfg = c;
    settings_applied++;
  endtask

  task automatic drive_scene(input int unsigned n_items);
    tick_t       t;
    int unsigned run_left, mood, pace, link_drop, roll;
    run_left  = 0;
    mood      = 0;
    pace      = 0;
    link_drop = 0;
    repeat (n_items) begin
      if (run_left == 0) begin
        run_left = $urandom_range(3, 40);
        mood     = $urandom_range(0, 5);
        pace     = $urandom_range(0, 3);
      end
      run_left--;
      case (mood)
        0: t.brightness = level_between('0, lamp_cfg.tunnel_level);
        1: t.brightness = level_between(lamp_cfg.tunnel_level, lamp_cfg.dusk_level);
        2: t.brightness = level_between(lamp_cfg.dusk_level, lamp_cfg.off_level);
        3: t.brightness = level_between(lamp_cfg.off_level, LevelMax);
        4: t.brightness = level_between(lamp_cfg.off_tunnel_level, lamp_cfg.off_level);
        default: t.brightness = LevelW'($urandom);
      endcase
      case (pace)
        0: t.speed = SpeedW'($urandom_range(0, LowSpeedCentiKmh));
        1: t.speed = SpeedW'($urandom_range(1000, 12000));
        2: t.speed = SpeedW'($urandom_range(5000, 30000));
        default: t.speed = SpeedW'($urandom);
      endcase
      t.tick_len = ($urandom_range(0, 9) == 0) ? TickW'($urandom_range(0, 99)) :
                                                 TickW'($urandom_range(100, TickMax));
      roll = $urandom_range(0, 99);
      if (roll < 2) now_ms = $urandom;
      else if (roll == 2) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      else if (roll == 3) now_ms = '0;
      else now_ms = now_ms + t.tick_len;
      t.stamp = now_ms;
      if (link_drop == 0 && $urandom_range(0, 99) < 3) link_drop = $urandom_range(1, 4);
      t.link = (link_drop == 0);
      if (link_drop != 0) link_drop--;
      send_tick(t);
    end
  endtask

  task automatic test_startup_grace();
    send_tick(tick_word('0, '0, '0, '0, 1'b0));
    send_tick(tick_word('0, SpeedMax, TickMax, 32'hFFFF_FFFF, 1'b0));
    now_ms = 32'd1200;
    send_tick(tick_word(LevelMax, 15'd2000, 10'd100, now_ms, 1'b1));
    send_tick(tick_word(12'd1229, 15'd2000, 10'd100, now_ms + 32'd1000, 1'b1));
    send_tick(tick_word(LevelMax, 15'd2000, 10'd100, now_ms + 32'd2000, 1'b0));
    send_tick(tick_word(LevelMax, 15'd2000, 10'd100, now_ms + 32'd3000, 1'b1));
    // The grace phase ends and the link is lost in one word: either through a dark
    // scene at the threshold or through the window running out.
    if ($urandom_range(0, 1) == 0) begin
      send_tick(tick_word(12'd1228, 15'd2000, 10'd100, now_ms + 32'd4000, 1'b0));
    end else begin
      send_tick(tick_word(LevelMax, 15'd2000, 10'd100, now_ms + 32'd4999, 1'b0));
      send_tick(tick_word(LevelMax, 15'd2000, 10'd100, now_ms + 32'd5000, 1'b0));
    end
    send_tick(tick_word(LevelMax, 15'd2000, 10'd100, now_ms + 32'd5100, 1'b1));
  endtask

  task automatic test_dark_and_distance_switching();
    // A dark period that begins at time stamp zero restarts its timing on the next word.
    send_tick(tick_word(12'd100, 15'd500, '0, 32'd0, 1'b1));
    send_tick(tick_word(12'd100, 15'd500, '0, 32'd1000, 1'b1));
    send_tick(tick_word(12'd100, 15'd500, '0, 32'd3999, 1'b1));
    send_tick(tick_word(12'd409, 15'd1000, '0, 32'd4000, 1'b1));
    send_tick(tick_word(LevelMax, SpeedMax, TickMax, 32'd5000, 1'b1));
    send_tick(tick_word(LevelMax, SpeedMax, TickMax, 32'd13999, 1'b1));
    send_tick(tick_word(LevelMax, SpeedMax, TickMax, 32'd14000, 1'b1));
    send_tick(tick_word('0, 15'd20000, 10'd1000, 32'd15000, 1'b1));
    send_tick(tick_word(12'd1638, 15'd30000, TickMax, 32'd26000, 1'b1));
    send_tick(tick_word(12'd2048, 15'd30000, TickMax, 32'd27000, 1'b1));
    send_tick(tick_word(12'd1000, 15'd30000, TickMax, 32'd28000, 1'b1));
    send_tick(tick_word(12'd1000, 15'd30000, TickMax, 32'd29000, 1'b1));
    send_tick(tick_word(12'd3000, 15'd30000, TickMax, 32'd30000, 1'b0));
    send_tick(tick_word(12'd3000, '0, '0, 32'd31000, 1'b1));
    now_ms = 32'd31000;
  endtask

  task automatic test_accumulator_saturation();
    cfg_t        c;
    int unsigned guard;
    c.startup_dark_level = LevelW'($urandom);
    c.dusk_level         = LevelMax;
    c.tunnel_level       = '0;
    c.off_level          = '0;
    c.off_tunnel_level   = LevelMax;
    c.dusk_distance_mm   = AccMax;
    c.tunnel_distance_mm = AccMax;
    c.off_distance_mm    = AccMax;
    drain_pipeline();
    program_regs(c);
    guard = 0;
    while (!lamp_lit && guard < 300) begin
      now_ms = now_ms + TickMax;
      send_tick(tick_word(LevelW'($urandom_range(1, LevelMax)), SpeedMax, TickMax, now_ms,
                          1'b1));
      guard++;
    end
    guard = 0;
    while (lamp_lit && guard < 300) begin
      now_ms = now_ms + TickMax;
      send_tick(tick_word(LevelW'($urandom_range(1, LevelMax)), SpeedMax, TickMax, now_ms,
                          1'b1));
      guard++;
    end
  endtask

  task automatic test_random_driving();
    cfg_t c;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: c = reset_settings();
        1: begin
          c = cfg_t'($urandom);
          c.startup_dark_level = LevelW'($urandom);
          c.dusk_level         = LevelW'($urandom_range(600, 2000));
          c.tunnel_level       = LevelW'($urandom_range(100, 600));
          c.off_level          = LevelW'($urandom_range(2000, 3500));
          c.off_tunnel_level   = LevelW'($urandom_range(1000, 3000));
          c.dusk_distance_mm   = DistW'($urandom_range(0, 20000));
          c.tunnel_distance_mm = DistW'($urandom_range(0, 20000));
          c.off_distance_mm    = DistW'($urandom_range(0, 20000));
        end
        2: c = '0;
        3: c = '1;
        default: begin
          c.startup_dark_level = LevelW'($urandom);
          c.dusk_level         = LevelW'($urandom);
          c.tunnel_level       = LevelW'($urandom);
          c.off_level          = LevelW'($urandom);
          c.off_tunnel_level   = LevelW'($urandom);
          c.dusk_distance_mm   = DistW'($urandom_range(0, 300000));
          c.tunnel_distance_mm = DistW'($urandom_range(0, 100000));
          c.off_distance_mm    = ($urandom_range(0, 3) == 0) ? DistW'($urandom) :
                                                               DistW'($urandom_range(0, 300000));
        end
      endcase
      drain_pipeline();
      program_regs(c);
      drive_scene(PhaseItems);
    end
  endtask

  // Result check against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    lamp_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, light_on %0d", $time, light_on_o);
      end else begin
        want = status_q.pop_front();
        check_field("light_on", 32'(want.light_on), 32'(light_on_o));
        check_field("in_startup", 32'(want.in_startup), 32'(in_startup_o));
        check_field("dusk_accum_mm", 32'(want.dusk_mm), 32'(dusk_accum_mm_o));
        check_field("off_accum_mm", 32'(want.off_mm), 32'(off_accum_mm_o));
        words_checked++;
      end
      if (light_on_o && !last_light) switch_ons++;
      last_light <= light_on_o;
    end
  end

  // Receiver stalls and sender pacing, with calm stretches in between.
  always @(posedge clk_i) begin
    if (mood_left == 0) begin
      mood_left <= $urandom_range(30, 400);
      calm_out  <= ($urandom_range(0, 3) == 0);
      calm_in   <= ($urandom_range(0, 3) == 0);
    end else begin
      mood_left <= mood_left - 1;
    end
    if (calm_out) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_ready_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 25) :
                                                   $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    brightness_i      <= '0;
    speed_centi_kmh_i <= '0;
    tick_ms_i         <= '0;
    time_ms_i         <= '0;
    link_active_i     <= 1'b0;
    out_ready_i       <= 1'b0;
    lamp_cfg   = reset_settings();
    started    = 1'b0;
    link_seen  = 1'b0;
    lamp_lit   = 1'b0;
    lit_since  = '0;
    link_since = '0;
    dark_since = '0;
    tunnel_acc = '0;
    dusk_acc   = '0;
    off_acc    = '0;
    exit_acc   = '0;
    now_ms     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_startup_grace();
    test_dark_and_distance_switching();
    test_accumulator_saturation();
    test_random_driving();
    drain_pipeline();

    $display("Sent %0d tick words under %0d register settings; %0d results checked.",
             words_sent, settings_applied, words_checked);
    $display("The lamp switched on %0d times; %0d mismatches were found.",
             switch_ons, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
